// ===== rtl/core/mrrc_pkg.sv =====
// ----------------------------------------------------------------------------
// mrrc_pkg
// shared types and constants for the miller-rabin round checker
// ----------------------------------------------------------------------------
package mrrc_pkg;

    localparam int NUM_WIDTH = 64;
    localparam int RND_WIDTH = 64;
    localparam int CNT_WIDTH = $clog2(NUM_WIDTH + 1);

    typedef logic [NUM_WIDTH-1:0] num_t;
    typedef logic [CNT_WIDTH-1:0] cnt_t;

    // shared unit operations
    typedef enum logic [1:0] {
        OP_MULMOD = 2'd0,
        OP_REMMOD = 2'd1
    } op_t;

    typedef struct packed {
        logic start;
        op_t  op;
    } unit_req_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SPLIT,
        ST_REM,
        ST_REM_WAIT,
        ST_POW,
        ST_POW_WAIT,
        ST_SQR,
        ST_SQR_WAIT,
        ST_TEST,
        ST_LOOP,
        ST_LOOP_WAIT,
        ST_DONE
    } state_t;

endpackage

// ===== rtl/core/mrrc_modunit.sv =====
// ----------------------------------------------------------------------------
// mrrc_modunit
// bit-serial shared modular unit: (a*b) mod m by add-and-double, or
// b mod m by restoring shift-subtract, one bit per cycle
// ----------------------------------------------------------------------------
module mrrc_modunit (
    input  logic                aclk,
    input  logic                aresetn,
    input  mrrc_pkg::unit_req_t req,
    input  mrrc_pkg::num_t      op_a,
    input  logic [mrrc_pkg::RND_WIDTH-1:0] op_b,
    input  mrrc_pkg::num_t      op_m,
    output logic                busy,
    output mrrc_pkg::num_t      result
);
    import mrrc_pkg::*;

    localparam int BW = RND_WIDTH;
    localparam int IW = $clog2(BW);

    logic              busy_reg, busy_next;
    op_t               op_reg, op_next;
    logic [IW-1:0]     idx_reg, idx_next;
    num_t              acc_reg, acc_next;
    num_t              a_reg, a_next;
    logic [BW-1:0]     b_reg, b_next;
    num_t              m_reg, m_next;

    logic [NUM_WIDTH:0] dbl;
    logic [NUM_WIDTH:0] dbl_red;
    num_t               dbl_mod;
    logic [NUM_WIDTH:0] add;
    logic [NUM_WIDTH:0] add_red;
    num_t               step;
    logic               bit_cur;

    always_comb begin
        bit_cur = b_reg[idx_reg];
        // double with the next bit shifted in for remainder, plain double for product
        dbl     = {acc_reg, (op_reg == OP_REMMOD) ? bit_cur : 1'b0};
        dbl_red = dbl - {1'b0, m_reg};
        dbl_mod = dbl_red[NUM_WIDTH] ? dbl[NUM_WIDTH-1:0] : dbl_red[NUM_WIDTH-1:0];
        add     = {1'b0, dbl_mod} + {1'b0, a_reg};
        add_red = add - {1'b0, m_reg};
        if (op_reg == OP_MULMOD && bit_cur) begin
            step = add_red[NUM_WIDTH] ? add[NUM_WIDTH-1:0] : add_red[NUM_WIDTH-1:0];
        end else begin
            step = dbl_mod;
        end
    end

    always_comb begin
        busy_next = busy_reg;
        op_next   = op_reg;
        idx_next  = idx_reg;
        acc_next  = acc_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        m_next    = m_reg;
        if (req.start) begin
            busy_next = 1'b1;
            op_next   = req.op;
            idx_next  = IW'(BW - 1);
            acc_next  = '0;
            a_next    = op_a;
            b_next    = op_b;
            m_next    = op_m;
        end else if (busy_reg) begin
            acc_next = step;
            if (idx_reg == '0) begin
                busy_next = 1'b0;
            end else begin
                idx_next = idx_reg - IW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
        end
        op_reg  <= op_next;
        idx_reg <= idx_next;
        acc_reg <= acc_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
        m_reg   <= m_next;
    end

    assign busy   = busy_reg;
    assign result = acc_reg;

endmodule

// ===== rtl/core/miller_rabin_round_checker.sv =====
// ----------------------------------------------------------------------------
// miller_rabin_round_checker
// one miller-rabin round per input transfer, verdict accumulated per candidate
// ----------------------------------------------------------------------------
// usage:
//   s_ channel carries candidate, random_value and last_round; m_ channel
//   returns round_passed, probably_prime and final_res, one result per round.
//   s_ready is high only while the sequencer is idle; a round runs to the end
//   before the next transfer is taken.
// sequence:
//   every modular operation is one bit-serial pass of the shared unit. a
//   round takes the witness remainder, up to 2 multiplies per exponent bit
//   and up to r-1 squarings; trivial and even candidates skip all of them.
// reset:
//   the accumulated pass flag returns to one, the sequencer to idle, m_valid to low.
// stall:
//   the result stays in the output register until m_ready takes it; the next
//   round may still be taken and run, and it waits at its end until the
//   output register is free.
// ----------------------------------------------------------------------------
module miller_rabin_round_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [mrrc_pkg::NUM_WIDTH-1:0] s_candidate,
    input  logic [mrrc_pkg::RND_WIDTH-1:0] s_random_value,
    input  logic                          s_last_round,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_round_passed,
    output logic                          m_probably_prime,
    output logic                          m_final_res
);
    import mrrc_pkg::*;

    state_t state_reg, state_next;

    // round operands
    num_t n_reg, n_next;
    logic [RND_WIDTH-1:0] rnd_reg, rnd_next;
    logic last_reg, last_next;
    num_t d_reg, d_next;        // exponent, shifted right as it is consumed
    cnt_t r_reg, r_next;        // powers of two in n-1
    num_t base_reg, base_next;  // running square of the witness
    num_t x_reg, x_next;        // running result
    logic pend_sqr_reg, pend_sqr_next;
    logic pass_reg, pass_next;
    logic all_reg, all_next;
    logic loop_reg, loop_next;  // set once a further squaring has been done

    // output register
    logic m_valid_reg, m_valid_next;
    logic res_pass_reg, res_pass_next;
    logic res_prime_reg, res_prime_next;
    logic res_final_reg, res_final_next;

    // shared unit
    unit_req_t req;
    num_t      u_a;
    logic [RND_WIDTH-1:0] u_b;
    num_t      u_m;
    logic      u_busy;
    num_t      u_res;

    num_t n_m1;
    num_t n_m4;
    logic test_pass;

    assign n_m1 = n_reg - num_t'(1);
    assign n_m4 = n_reg - num_t'(4);
    // x of one only counts before any further squaring
    assign test_pass = (x_reg == num_t'(1) && !loop_reg) || x_reg == n_m1;

    mrrc_modunit u_modunit (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (req),
        .op_a    (u_a),
        .op_b    (u_b),
        .op_m    (u_m),
        .busy    (u_busy),
        .result  (u_res)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (n_reg <= num_t'(4) || !n_reg[0]) begin
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_SPLIT;
                end
            end
            ST_SPLIT: begin
                if (d_reg[0]) begin
                    state_next = ST_REM;
                end
            end
            ST_REM:      state_next = ST_REM_WAIT;
            ST_REM_WAIT: begin
                if (!u_busy) begin
                    state_next = ST_POW;
                end
            end
            ST_POW: begin
                if (pend_sqr_reg) begin
                    state_next = ST_SQR;
                end else if (d_reg == '0) begin
                    state_next = ST_TEST;
                end else if (d_reg[0]) begin
                    state_next = ST_POW_WAIT;
                end else begin
                    state_next = ST_SQR;
                end
            end
            ST_POW_WAIT: begin
                if (!u_busy) begin
                    state_next = ST_POW;
                end
            end
            ST_SQR:      state_next = ST_SQR_WAIT;
            ST_SQR_WAIT: begin
                if (!u_busy) begin
                    state_next = ST_POW;
                end
            end
            ST_TEST: begin
                if (test_pass || r_reg <= cnt_t'(1)) begin
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_LOOP;
                end
            end
            ST_LOOP:      state_next = ST_LOOP_WAIT;
            ST_LOOP_WAIT: begin
                if (!u_busy) begin
                    state_next = ST_TEST;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath and unit control
    always_comb begin
        n_next         = n_reg;
        rnd_next       = rnd_reg;
        last_next      = last_reg;
        d_next         = d_reg;
        r_next         = r_reg;
        base_next      = base_reg;
        x_next         = x_reg;
        pend_sqr_next  = pend_sqr_reg;
        pass_next      = pass_reg;
        all_next       = all_reg;
        loop_next      = loop_reg;
        m_valid_next   = m_valid_reg;
        res_pass_next  = res_pass_reg;
        res_prime_next = res_prime_reg;
        res_final_next = res_final_reg;
        req.start      = 1'b0;
        req.op         = OP_MULMOD;
        u_a            = x_reg;
        u_b            = RND_WIDTH'(base_reg);
        u_m            = n_reg;
        s_ready        = (state_reg == ST_IDLE);

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    n_next    = s_candidate;
                    rnd_next  = s_random_value;
                    last_next = s_last_round;
                end
            end
            ST_CHECK: begin
                pass_next = (n_reg == num_t'(2) || n_reg == num_t'(3));
                d_next    = n_m1;
                r_next    = '0;
            end
            ST_SPLIT: begin
                if (!d_reg[0]) begin
                    d_next = d_reg >> 1;
                    r_next = r_reg + cnt_t'(1);
                end
            end
            ST_REM: begin
                req.start = 1'b1;
                req.op    = OP_REMMOD;
                u_a       = '0;
                u_b       = rnd_reg;
                u_m       = n_m4;
            end
            ST_REM_WAIT: begin
                if (!u_busy) begin
                    base_next     = u_res + num_t'(2);
                    x_next        = num_t'(1);
                    pend_sqr_next = 1'b0;
                    loop_next     = 1'b0;
                end
            end
            ST_POW: begin
                if (pend_sqr_reg) begin
                    pend_sqr_next = 1'b0;
                end else if (d_reg != '0 && d_reg[0]) begin
                    // x = x * base
                    req.start     = 1'b1;
                    u_a           = x_reg;
                    u_b           = RND_WIDTH'(base_reg);
                    pend_sqr_next = 1'b1;
                end
            end
            ST_POW_WAIT: begin
                if (!u_busy) begin
                    x_next = u_res;
                end
            end
            ST_SQR: begin
                req.start = 1'b1;
                u_a       = base_reg;
                u_b       = RND_WIDTH'(base_reg);
            end
            ST_SQR_WAIT: begin
                if (!u_busy) begin
                    base_next = u_res;
                    d_next    = d_reg >> 1;
                end
            end
            ST_TEST: begin
                pass_next = test_pass;
            end
            ST_LOOP: begin
                req.start = 1'b1;
                u_a       = x_reg;
                u_b       = RND_WIDTH'(x_reg);
            end
            ST_LOOP_WAIT: begin
                if (!u_busy) begin
                    x_next    = u_res;
                    r_next    = r_reg - cnt_t'(1);
                    loop_next = 1'b1;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next   = 1'b1;
                    res_pass_next  = pass_reg;
                    res_prime_next = all_reg & pass_reg;
                    res_final_next = last_reg;
                    all_next       = last_reg ? 1'b1 : (all_reg & pass_reg);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            all_reg     <= 1'b1;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            all_reg     <= all_next;
            m_valid_reg <= m_valid_next;
        end
        n_reg         <= n_next;
        rnd_reg       <= rnd_next;
        last_reg      <= last_next;
        d_reg         <= d_next;
        r_reg         <= r_next;
        base_reg      <= base_next;
        x_reg         <= x_next;
        pend_sqr_reg  <= pend_sqr_next;
        pass_reg      <= pass_next;
        loop_reg      <= loop_next;
        res_pass_reg  <= res_pass_next;
        res_prime_reg <= res_prime_next;
        res_final_reg <= res_final_next;
    end

    assign m_valid          = m_valid_reg;
    assign m_round_passed   = res_pass_reg;
    assign m_probably_prime = res_prime_reg;
    assign m_final_res      = res_final_reg;

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the miller-rabin round checker: rounds on trivial,
// even, small and large prime and composite candidates, compared against a
// local primality-round model with a per-candidate verdict flag
// ----------------------------------------------------------------------------
module tb;

    import mrrc_pkg::*;

    localparam int RESET_CYCLES = 12;
    localparam int IDLE_LIMIT   = 200000;
    localparam int TAIL_CYCLES  = 100;
    localparam int MAX_SHOWN    = 10;

    typedef struct packed {
        logic round_passed;
        logic probably_prime;
        logic final_res;
    } verdict_t;

    logic aclk;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    num_t s_candidate;
    logic [RND_WIDTH-1:0] s_random_value;
    logic s_last_round;
    logic m_valid;
    logic m_ready;
    logic m_round_passed;
    logic m_probably_prime;
    logic m_final_res;

    miller_rabin_round_checker DUT (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_candidate      (s_candidate),
        .s_random_value   (s_random_value),
        .s_last_round     (s_last_round),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_round_passed   (m_round_passed),
        .m_probably_prime (m_probably_prime),
        .m_final_res      (m_final_res)
    );

    // expected verdicts, oldest first
    verdict_t verdict_q[$];
    // predictor copy of the accumulated flag
    logic     passed_so_far;

    int  mismatches;
    int  rounds_sent;
    int  verdicts_seen;
    int  composite_verdicts;
    int  idle_cycles;
    bit  timed_out;
    bit  hold_off;   // long receiver stall requested by the backpressure test

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // ------------------------------------------------------------------------
    // predictor: one round on candidate n with witness 2 + rnd mod (n-4)
    // ------------------------------------------------------------------------
    function automatic logic [63:0] mulmod(logic [63:0] a, logic [63:0] b,
                                           logic [63:0] m);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return 64'(p % {64'd0, m});
    endfunction

    function automatic logic [63:0] powmod(logic [63:0] base, logic [63:0] e,
                                           logic [63:0] m);
        logic [63:0] acc;
        acc = 64'd1;
        while (e != 0) begin
            if (e[0]) acc = mulmod(acc, base, m);
            base = mulmod(base, base, m);
            e = e >> 1;
        end
        return acc;
    endfunction

    function automatic logic round_verdict(logic [63:0] n, logic [63:0] rnd);
        logic [63:0] d;
        logic [63:0] x;
        int          r;
        if (n <= 1 || n == 4) return 1'b0;
        if (n <= 3) return 1'b1;
        if (!n[0]) return 1'b0;
        d = n - 1;
        r = 0;
        while (!d[0]) begin
            d = d >> 1;
            r++;
        end
        x = powmod(64'd2 + rnd % (n - 4), d, n);
        if (x == 1 || x == n - 1) return 1'b1;
        for (int j = 1; j < r; j++) begin
            x = mulmod(x, x, n);
            if (x == n - 1) return 1'b1;
        end
        return 1'b0;
    endfunction

    // ------------------------------------------------------------------------
    // sender: one round per call, waits for the transfer
    // ------------------------------------------------------------------------
    task automatic send_round(num_t n, logic [63:0] rnd, logic last);
        verdict_t v;
        s_valid        <= 1'b1;
        s_candidate    <= n;
        s_random_value <= rnd;
        s_last_round   <= last;
        do @(posedge aclk); while (!s_ready);
        v.round_passed   = round_verdict(n, rnd);
        passed_so_far    = passed_so_far & v.round_passed;
        v.probably_prime = passed_so_far;
        v.final_res      = last;
        if (last) passed_so_far = 1'b1;
        verdict_q.push_back(v);
        rounds_sent++;
        // random gap between bursts
        if ($urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
    endtask

    // a whole candidate: k rounds, the last one marked
    task automatic check_candidate(num_t n, int k);
        for (int i = 0; i < k; i++)
            send_round(n, {$urandom, $urandom}, i == k - 1);
    endtask

    // odd value of at most the given bit width, usually with small cofactors left in
    function automatic num_t random_odd(int bits);
        num_t v;
        v = {$urandom, $urandom};
        if (bits < 64) v = v & ((num_t'(1) << bits) - 1);
        return v | 64'd1;
    endfunction

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    task automatic test_trivial_candidates();
        // zero, one and four composite; two and three prime; random unused
        send_round(64'd0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
        send_round(64'd1, 64'd0, 1'b1);
        send_round(64'd2, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
        send_round(64'd3, 64'd0, 1'b1);
        send_round(64'd4, 64'h1234, 1'b1);
        // five: witness is always two
        send_round(64'd5, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
        // even candidates above four, including the top even value
        send_round(64'd6, 64'd7, 1'b0);
        send_round(64'hFFFF_FFFF_FFFF_FFFE, 64'd0, 1'b1);
    endtask

    task automatic test_known_candidates();
        // largest 64-bit prime and all-ones composite
        send_round(64'hFFFF_FFFF_FFFF_FFC5, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
        send_round(64'hFFFF_FFFF_FFFF_FFC5, 64'd0, 1'b1);
        send_round(64'hFFFF_FFFF_FFFF_FFFF, 64'h5555_AAAA_5555_AAAA, 1'b1);
        // carmichael 561 and a strong pseudoprime to base 2 (2047)
        send_round(64'd561, 64'd0, 1'b0);
        send_round(64'd2047, 64'd0, 1'b0);
        send_round(64'd2047, 64'd5, 1'b1);
        // prime with many factors of two in n-1 (2^16+1)
        send_round(64'd65537, 64'hAAAA_5555_AAAA_5555, 1'b1);
        // flag accumulation across a failing middle round
        send_round(64'd7, 64'd1, 1'b0);
        send_round(64'd9, 64'd1, 1'b0);
        send_round(64'd7, 64'd2, 1'b1);
    endtask

    task automatic test_random_candidates();
        num_t n;
        for (int i = 0; i < 30; i++) begin
            case ($urandom_range(0, 5))
                0: n = num_t'($urandom_range(0, 40));
                1: n = {$urandom, $urandom};
                2: n = random_odd($urandom_range(8, 40));
                default: n = random_odd(64);
            endcase
            check_candidate(n, $urandom_range(1, 4));
        end
    endtask

    task automatic test_backpressure();
        // receiver holds off while the sender keeps offering rounds
        hold_off = 1'b1;
        fork
            begin
                repeat (3000) @(posedge aclk);
                hold_off = 1'b0;
            end
            check_candidate(64'd97, 3);
        join
    endtask

    // ------------------------------------------------------------------------
    // receiver stall pattern: stretches of free flow and random stalls
    // ------------------------------------------------------------------------
    initial begin
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_off)
                m_ready <= 1'b0;
            else if ((rounds_sent / 16) % 2 == 1)
                m_ready <= 1'b1;
            else
                m_ready <= ($urandom_range(0, 2) != 0);
        end
    end

    // ------------------------------------------------------------------------
    // checker: every result transfer against the oldest expectation
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        verdict_t want;
        if (aresetn && m_valid && m_ready) begin
            verdicts_seen++;
            if (verdict_q.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_SHOWN)
                    $display("error: unexpected result transfer at %0t", $time);
            end else begin
                want = verdict_q.pop_front();
                if (!want.probably_prime) composite_verdicts++;
                if (want.round_passed !== m_round_passed ||
                    want.probably_prime !== m_probably_prime ||
                    want.final_res !== m_final_res) begin
                    mismatches++;
                    if (mismatches <= MAX_SHOWN)
                        $display("error: pass/prime/final expected %b%b%b got %b%b%b",
                                 want.round_passed, want.probably_prime, want.final_res,
                                 m_round_passed, m_probably_prime, m_final_res);
                end
            end
        end
    end

    // watchdog on cycles with no transfer on either side
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT && !timed_out) begin
            timed_out = 1'b1;
            $display("error: no transfer for %0d cycles", IDLE_LIMIT);
            $display("FAIL miller_rabin_round_checker");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin
        aresetn        <= 1'b0;
        s_valid        <= 1'b0;
        s_candidate    <= '0;
        s_random_value <= '0;
        s_last_round   <= 1'b0;
        passed_so_far  = 1'b1;
        mismatches     = 0;
        rounds_sent    = 0;
        verdicts_seen  = 0;
        composite_verdicts = 0;
        idle_cycles    = 0;
        timed_out      = 1'b0;
        hold_off       = 1'b0;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_trivial_candidates();
        test_known_candidates();
        test_backpressure();
        test_random_candidates();
        s_valid <= 1'b0;

        while (verdict_q.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("covered %0d rounds, %0d results, %0d composite verdicts",
                 rounds_sent, verdicts_seen, composite_verdicts);
        $display("trivial, even, pseudoprime, extreme and random candidates, with stalls");
        if (mismatches == 0 && verdict_q.size() == 0)
            $display("PASS miller_rabin_round_checker");
        else
            $display("FAIL miller_rabin_round_checker");
        $finish;
    end

endmodule
